@@ sv/audio_container_sniffer_assert.svh @@
// Assertion macros shared by the sniffer RTL.
// Needs a clk and an arst_n in the scope of every use; no other dependencies.
`ifndef AUDIO_CONTAINER_SNIFFER_ASSERT_SVH
`define AUDIO_CONTAINER_SNIFFER_ASSERT_SVH
`ifndef SYNTHESIS
// property checked on every rising edge out of reset
`define ACS_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("acs assertion failed");
// condition in one cycle implies outcome in the next
`define ACS_ASSERT_NEXT(name, cond, outcome) \
	`ACS_ASSERT(name, (cond) |=> (outcome))
`else
`define ACS_ASSERT(name, prop)
`define ACS_ASSERT_NEXT(name, cond, outcome)
`endif
`endif

@@ sv/acs_pkg.sv @@
// Types and constants shared by the audio container sniffer.
// No dependencies.
package acs_pkg;

	localparam int unsigned CNT_W       = 11;
	localparam int unsigned WIN_LEN     = 10;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CNT_W-1:0] CNT_MAX   = '1;
	localparam logic [CNT_W-1:0] LEN_MIN   = 11'd12;
	localparam logic [CNT_W-1:0] LEN_GUID  = 11'd16;
	localparam logic [CNT_W-1:0] LEN_XM    = 11'd17;
	localparam logic [CNT_W-1:0] LEN_SCRM  = 11'd48;
	localparam logic [CNT_W-1:0] LEN_MOD   = 11'd1084;
	localparam logic [CNT_W-1:0] MOD_FIRST = 11'd1080;
	localparam logic [CNT_W-1:0] MOD_LAST  = 11'd1083;

	typedef enum logic [1:0] {
		OGG_NONE  = 2'd0,
		OGG_OPUS  = 2'd1,
		OGG_FLAC  = 2'd2,
		OGG_SPEEX = 2'd3
	} ogg_hit_t;

	typedef enum logic [4:0] {
		FMT_UNKNOWN = 5'd0,  FMT_MP3    = 5'd1,  FMT_FLAC   = 5'd2,  FMT_M4A   = 5'd3,
		FMT_OGG     = 5'd4,  FMT_OPUS   = 5'd5,  FMT_OGGFLAC = 5'd6, FMT_SPEEX = 5'd7,
		FMT_WAV     = 5'd8,  FMT_AIFF   = 5'd9,  FMT_ASF    = 5'd10, FMT_DSF   = 5'd11,
		FMT_DSDIFF  = 5'd12, FMT_APE    = 5'd13, FMT_WV     = 5'd14, FMT_MPC   = 5'd15,
		FMT_TTA     = 5'd16, FMT_SHN    = 5'd17, FMT_MKV    = 5'd18, FMT_IT    = 5'd19,
		FMT_XM      = 5'd20, FMT_S3M    = 5'd21, FMT_MOD    = 5'd22
	} fmt_t;

	// raw signature matches, before length guards and priority
	typedef struct packed {
		logic id3_mpeg;
		logic flac;
		logic ftyp;
		logic ogg;
		logic riff_wave;
		logic form_aiff;
		logic asf;
		logic dsd;
		logic frm8_dsd;
		logic mac;
		logic wvpk;
		logic mpc;
		logic tta;
		logic ajkg;
		logic ebml;
		logic impm;
		logic xm;
		logic scrm;
		logic mod_tag;
	} sig_flags_t;

	typedef struct packed {
		logic [CNT_W-1:0] len;
		ogg_hit_t         hit;
		sig_flags_t       sig;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ sv/audio_container_sniffer.sv @@
// Top level of the audio container sniffer: front end, job queue, classifier.
// Depends on acs_pkg, acs_front, acs_queue and acs_back.
//
//  channel  valid        ready        payload
//  bytes    byte_valid   byte_ready   data_byte, is_last
//  codes    code_valid   code_ready   format_code
//
// One byte word is taken every cycle while byte_ready is high; the front end
// only does fixed compares. Each code is queued, then registered at the output.
// Reset clears the count and the Ogg hit state at once; no clearing pass.
// byte_ready drops only while two finished files wait in the job queue.
module audio_container_sniffer #(
	parameter int unsigned OGG_SCAN_LIMIT = 200,
	parameter int unsigned HEADER_BYTES   = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	output logic       code_valid,
	input  logic       code_ready,
	output logic [4:0] format_code
);

	logic               push;
	logic               pop;
	acs_pkg::job_t      job;
	acs_pkg::job_t      head;
	acs_pkg::q_status_t q_status;

	acs_front #(
		.OGG_SCAN_LIMIT(OGG_SCAN_LIMIT),
		.HEADER_BYTES  (HEADER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.data_byte (data_byte),
		.is_last   (is_last),
		.q_status  (q_status),
		.push      (push),
		.job       (job)
	);

	acs_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.job_in(job),
		.pop   (pop),
		.head  (head),
		.status(q_status)
	);

	acs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.head       (head),
		.pop        (pop),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.format_code(format_code)
	);

endmodule

@@ sv/acs_front.sv @@
// Front end: takes bytes, keeps header, tag, scan window and count,
// and on the last byte queues the signature matches. Uses acs_pkg.
`include "audio_container_sniffer_assert.svh"
module acs_front #(
	parameter int unsigned OGG_SCAN_LIMIT = 200,
	parameter int unsigned HEADER_BYTES   = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  logic [7:0]          data_byte,
	input  logic                is_last,
	input  acs_pkg::q_status_t  q_status,
	output logic                push,
	output acs_pkg::job_t       job
);

	localparam int unsigned CW = acs_pkg::CNT_W;
	localparam int unsigned WL = acs_pkg::WIN_LEN;
	localparam logic [CW-1:0] SCAN_LIMIT = CW'(OGG_SCAN_LIMIT);

	localparam logic [23:0]  SIG_ID3   = "ID3";
	localparam logic [31:0]  SIG_FLAC  = "fLaC";
	localparam logic [31:0]  SIG_FTYP  = "ftyp";
	localparam logic [31:0]  SIG_OGGS  = "OggS";
	localparam logic [31:0]  SIG_RIFF  = "RIFF";
	localparam logic [31:0]  SIG_WAVE  = "WAVE";
	localparam logic [31:0]  SIG_FORM  = "FORM";
	localparam logic [31:0]  SIG_AIFF  = "AIFF";
	localparam logic [31:0]  SIG_AIFC  = "AIFC";
	localparam logic [63:0]  SIG_ASF   = 64'h3026_B275_8E66_CF11;
	localparam logic [31:0]  SIG_DSD   = "DSD ";
	localparam logic [31:0]  SIG_FRM8  = "FRM8";
	localparam logic [31:0]  SIG_MAC   = "MAC ";
	localparam logic [31:0]  SIG_WVPK  = "wvpk";
	localparam logic [23:0]  SIG_MPP   = "MP+";
	localparam logic [31:0]  SIG_MPCK  = "MPCK";
	localparam logic [31:0]  SIG_TTA   = "TTA1";
	localparam logic [31:0]  SIG_AJKG  = "ajkg";
	localparam logic [31:0]  SIG_EBML  = 32'h1A45_DFA3;
	localparam logic [31:0]  SIG_IMPM  = "IMPM";
	localparam logic [127:0] SIG_XM    = "Extended Module:";
	localparam logic [31:0]  SIG_SCRM  = "SCRM";
	localparam logic [39:0]  SIG_OFLAC = {8'h7F, "FLAC"};
	localparam logic [63:0]  SIG_OPUS  = "OpusHead";
	localparam logic [63:0]  SIG_SPEEX = "Speex   ";
	localparam logic [31:0]  TAG_MK    = "M.K.";
	localparam logic [31:0]  TAG_MKX   = "M!K!";
	localparam logic [31:0]  TAG_FLT4  = "FLT4";
	localparam logic [31:0]  TAG_FLT8  = "FLT8";
	localparam logic [31:0]  TAG_4CHN  = "4CHN";
	localparam logic [31:0]  TAG_6CHN  = "6CHN";
	localparam logic [31:0]  TAG_8CHN  = "8CHN";

	logic              accept;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     len_d;
	acs_pkg::ogg_hit_t hit_q;
	acs_pkg::ogg_hit_t hit_d;
	logic [7:0]        hdr_q [HEADER_BYTES];
	logic [7:0]        hdr_d [HEADER_BYTES];
	logic [7:0]        win_q [WL];
	logic [7:0]        win_d [WL];
	logic [31:0]       tag_q;
	logic [31:0]       tag_d;
	logic [31:0]       w0, w4, w8, w12, w44;
	logic [63:0]       w0_8;
	logic [127:0]      w0_16;
	logic [39:0]       win_head;
	logic [63:0]       win_tail;
	logic              flac_in_range;
	logic              text_in_range;
	acs_pkg::sig_flags_t sig;

	assign byte_ready = !q_status.full;
	assign accept     = byte_valid && byte_ready;
	assign push       = accept && is_last;

	// next-state views with the incoming byte merged in
	always_comb begin
		for (int i = 0; i < HEADER_BYTES; i++) begin
			hdr_d[i] = (count_q == CW'(i)) ? data_byte : hdr_q[i];
		end
		for (int i = 0; i < WL - 1; i++) begin
			win_d[i] = win_q[i + 1];
		end
		win_d[WL - 1] = data_byte;
	end

	assign tag_d = (count_q >= acs_pkg::MOD_FIRST && count_q <= acs_pkg::MOD_LAST) ?
		{tag_q[23:0], data_byte} : tag_q;
	assign len_d = (count_q == acs_pkg::CNT_MAX) ? count_q : count_q + CW'(1);

	assign w0    = {hdr_d[0], hdr_d[1], hdr_d[2], hdr_d[3]};
	assign w4    = {hdr_d[4], hdr_d[5], hdr_d[6], hdr_d[7]};
	assign w8    = {hdr_d[8], hdr_d[9], hdr_d[10], hdr_d[11]};
	assign w12   = {hdr_d[12], hdr_d[13], hdr_d[14], hdr_d[15]};
	assign w44   = {hdr_d[44], hdr_d[45], hdr_d[46], hdr_d[47]};
	assign w0_8  = {w0, w4};
	assign w0_16 = {w0, w4, w8, w12};

	assign win_head = {win_d[0], win_d[1], win_d[2], win_d[3], win_d[4]};
	assign win_tail = {win_d[1], win_d[2], win_d[3], win_d[4],
		win_d[5], win_d[6], win_d[7], win_d[8]};

	// FLAC mapping starts nine bytes back, the eight-byte tags eight back
	assign flac_in_range = count_q >= CW'(9) && (count_q - CW'(9)) < SCAN_LIMIT;
	assign text_in_range = count_q >= CW'(8) && (count_q - CW'(8)) < SCAN_LIMIT;

	always_comb begin
		hit_d = hit_q;
		if (hit_q == acs_pkg::OGG_NONE) begin
			if (flac_in_range && win_head == SIG_OFLAC) begin
				hit_d = acs_pkg::OGG_FLAC;
			end else if (text_in_range && win_tail == SIG_OPUS) begin
				hit_d = acs_pkg::OGG_OPUS;
			end else if (text_in_range && win_tail == SIG_SPEEX) begin
				hit_d = acs_pkg::OGG_SPEEX;
			end
		end
	end

	always_comb begin
		sig.id3_mpeg  = w0[31:8] == SIG_ID3 || (w0[31:24] == 8'hFF && w0[23:21] == 3'b111);
		sig.flac      = w0 == SIG_FLAC;
		sig.ftyp      = w4 == SIG_FTYP;
		sig.ogg       = w0 == SIG_OGGS;
		sig.riff_wave = w0 == SIG_RIFF && w8 == SIG_WAVE;
		sig.form_aiff = w0 == SIG_FORM && (w8 == SIG_AIFF || w8 == SIG_AIFC);
		sig.asf       = w0_8 == SIG_ASF;
		sig.dsd       = w0 == SIG_DSD;
		sig.frm8_dsd  = w0 == SIG_FRM8 && w12 == SIG_DSD;
		sig.mac       = w0 == SIG_MAC;
		sig.wvpk      = w0 == SIG_WVPK;
		sig.mpc       = w0[31:8] == SIG_MPP || w0 == SIG_MPCK;
		sig.tta       = w0 == SIG_TTA;
		sig.ajkg      = w0 == SIG_AJKG;
		sig.ebml      = w0 == SIG_EBML;
		sig.impm      = w0 == SIG_IMPM;
		sig.xm        = w0_16 == SIG_XM;
		sig.scrm      = w44 == SIG_SCRM;
		sig.mod_tag   = tag_d == TAG_MK || tag_d == TAG_MKX || tag_d == TAG_FLT4 ||
			tag_d == TAG_FLT8 || tag_d == TAG_4CHN || tag_d == TAG_6CHN ||
			tag_d == TAG_8CHN;
	end

	assign job.len = len_d;
	assign job.hit = hit_d;
	assign job.sig = sig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hit_q   <= acs_pkg::OGG_NONE;
		end else if (accept) begin
			if (is_last) begin
				count_q <= '0;
				hit_q   <= acs_pkg::OGG_NONE;
			end else begin
				count_q <= len_d;
				hit_q   <= hit_d;
			end
		end
	end

	// stale bytes from an earlier file are never read: every check past
	// byte 11 sits behind a length guard
	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_q <= hdr_d;
			win_q <= win_d;
			tag_q <= tag_d;
		end
	end

	`ACS_ASSERT_NEXT(a_hit_kept, accept && !is_last && hit_q != acs_pkg::OGG_NONE,
		hit_q == $past(hit_q))
	`ACS_ASSERT_NEXT(a_clear_after_last, push, count_q == '0 && hit_q == acs_pkg::OGG_NONE)

endmodule

@@ sv/acs_queue.sv @@
// Short job queue between the byte front end and the classifier.
// Uses acs_pkg for the job and status types.
`include "audio_container_sniffer_assert.svh"
module acs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  acs_pkg::job_t      job_in,
	input  logic               pop,
	output acs_pkg::job_t      head,
	output acs_pkg::q_status_t status
);

	localparam int unsigned DEPTH = acs_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	acs_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign status.full  = fill_q == FILL_W'(DEPTH);
	assign status.empty = fill_q == '0;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	`ACS_ASSERT(a_no_push_full, push |-> !status.full)
	`ACS_ASSERT(a_no_pop_empty, pop |-> !status.empty)
	`ACS_ASSERT_NEXT(a_fill_up, push && !pop, fill_q == $past(fill_q) + 1)

endmodule

@@ sv/acs_back.sv @@
// Back end: applies length guards and check priority to a queued job,
// and holds the format code in an output register. Uses acs_pkg.
module acs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  acs_pkg::q_status_t q_status,
	input  acs_pkg::job_t      head,
	output logic               pop,
	output logic               code_valid,
	input  logic               code_ready,
	output logic [4:0]         format_code
);

	acs_pkg::fmt_t code_d;
	acs_pkg::fmt_t code_q;
	logic          valid_q;

	assign pop         = !q_status.empty && (!valid_q || code_ready);
	assign code_valid  = valid_q;
	assign format_code = code_q;

	always_comb begin
		code_d = acs_pkg::FMT_UNKNOWN;
		if (head.len < acs_pkg::LEN_MIN) begin
			code_d = acs_pkg::FMT_UNKNOWN;
		end else if (head.sig.id3_mpeg) begin
			code_d = acs_pkg::FMT_MP3;
		end else if (head.sig.flac) begin
			code_d = acs_pkg::FMT_FLAC;
		end else if (head.sig.ftyp) begin
			code_d = acs_pkg::FMT_M4A;
		end else if (head.sig.ogg) begin
			case (head.hit)
				acs_pkg::OGG_OPUS:  code_d = acs_pkg::FMT_OPUS;
				acs_pkg::OGG_FLAC:  code_d = acs_pkg::FMT_OGGFLAC;
				acs_pkg::OGG_SPEEX: code_d = acs_pkg::FMT_SPEEX;
				default:            code_d = acs_pkg::FMT_OGG;
			endcase
		end else if (head.len > acs_pkg::LEN_MIN && head.sig.riff_wave) begin
			code_d = acs_pkg::FMT_WAV;
		end else if (head.sig.form_aiff) begin
			code_d = acs_pkg::FMT_AIFF;
		end else if (head.len >= acs_pkg::LEN_GUID && head.sig.asf) begin
			code_d = acs_pkg::FMT_ASF;
		end else if (head.sig.dsd) begin
			code_d = acs_pkg::FMT_DSF;
		end else if (head.len >= acs_pkg::LEN_GUID && head.sig.frm8_dsd) begin
			code_d = acs_pkg::FMT_DSDIFF;
		end else if (head.sig.mac) begin
			code_d = acs_pkg::FMT_APE;
		end else if (head.sig.wvpk) begin
			code_d = acs_pkg::FMT_WV;
		end else if (head.sig.mpc) begin
			code_d = acs_pkg::FMT_MPC;
		end else if (head.sig.tta) begin
			code_d = acs_pkg::FMT_TTA;
		end else if (head.sig.ajkg) begin
			code_d = acs_pkg::FMT_SHN;
		end else if (head.sig.ebml) begin
			code_d = acs_pkg::FMT_MKV;
		end else if (head.sig.impm) begin
			code_d = acs_pkg::FMT_IT;
		end else if (head.len >= acs_pkg::LEN_XM && head.sig.xm) begin
			code_d = acs_pkg::FMT_XM;
		end else if (head.len >= acs_pkg::LEN_SCRM && head.sig.scrm) begin
			code_d = acs_pkg::FMT_S3M;
		end else if (head.len >= acs_pkg::LEN_MOD && head.sig.mod_tag) begin
			code_d = acs_pkg::FMT_MOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (code_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_q <= code_d;
		end
	end

endmodule
